[hw/rtl/mrsh_pkg.sv]
// Package for the multiply-rotate string hash.
// Holds the register indexes, the hash constants and the input beat type.
// No dependencies.
package mrsh_pkg;

	localparam int HASH_W = 64;
	localparam int HALF_W = 32;
	localparam int BYTE_W = 8;
	localparam int ROT_W  = 4;

	localparam logic [0:0] REG_SEED      = 1'd0;
	localparam logic [0:0] REG_WIDE_MODE = 1'd1;

	localparam logic [HASH_W-1:0] MUL_NARROW = 64'd439;
	localparam logic [HASH_W-1:0] MUL_WIDE   = 64'd5741;
	localparam logic [HASH_W-1:0] CHAR_MUL   = 64'd23;
	localparam logic [HASH_W-1:0] POS_BIAS   = 64'd257;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              no_byte;
		logic              last_byte;
	} item_t;

endpackage

[hw/rtl/mrsh_mix.sv]
// One absorb step of the hash: multiply-add of byte and position, then a rotate.
// Uses mrsh_pkg for widths and constants.
module mrsh_mix (
	input  logic [mrsh_pkg::HASH_W-1:0] hash_in,
	input  logic [mrsh_pkg::HASH_W-1:0] pos_in,
	input  logic [mrsh_pkg::BYTE_W-1:0] data_byte,
	input  logic                        wide,
	output logic [mrsh_pkg::HASH_W-1:0] hash_out
);
	import mrsh_pkg::*;

	logic [HASH_W-1:0]   c_sext;
	logic [HASH_W-1:0]   sum;
	logic [ROT_W-1:0]    rot;
	logic [2*HASH_W-1:0] wide_dbl;
	logic [2*HALF_W-1:0] narrow_dbl;

	assign c_sext = {{(HASH_W-BYTE_W){data_byte[BYTE_W-1]}}, data_byte};
	assign sum    = (wide ? hash_in * MUL_WIDE : hash_in * MUL_NARROW)
	              + c_sext * CHAR_MUL + pos_in + POS_BIAS;

	assign rot[0] = data_byte[0];
	assign rot[1] = data_byte[6] | data_byte[2];
	assign rot[2] = data_byte[4];
	assign rot[3] = data_byte[3] | data_byte[1];

	assign wide_dbl   = {sum, sum} << rot;
	assign narrow_dbl = {sum[HALF_W-1:0], sum[HALF_W-1:0]} << rot;

	assign hash_out = wide ? wide_dbl[2*HASH_W-1:HASH_W]
	                       : {{(HASH_W-HALF_W){1'b0}}, narrow_dbl[2*HALF_W-1:HALF_W]};

endmodule

[hw/rtl/mrsh_out.sv]
// Result register of the hash block: holds a finished hash until taken.
// Uses mrsh_pkg for the hash width.
module mrsh_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [mrsh_pkg::HASH_W-1:0] load_hash,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [mrsh_pkg::HASH_W-1:0] hash_value,
	output logic                        blocked
);
	import mrsh_pkg::*;

	logic              valid_q;
	logic [HASH_W-1:0] hash_q;

	assign blocked    = valid_q & out_stall;
	assign out_valid  = valid_q;
	assign hash_value = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hash_q <= load_hash;
		end
	end

endmodule

[hw/rtl/multiply_rotate_string_hash.sv]
// Top level of the multiply-rotate string hash: input register, hash state, result register.
// Uses mrsh_pkg, mrsh_mix and mrsh_out.
//
// Takes at most one string byte per beat and can accept a beat in every cycle while
// input stall is low. A beat is registered in the input register, then absorbed into
// the running hash by one constant multiply-add and a rotate of 0 to 15 bits; the beat
// marked last then loads the result register, which offers the hash until it is taken.
// The hash loop closes through that single multiply-add and rotate. Input stall is high
// during reset and until the ready register is set after it, and otherwise only while a
// last beat waits on a result that has not yet been taken.
module multiply_rotate_string_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [0:0]                  cfg_index,
	input  logic [mrsh_pkg::HASH_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mrsh_pkg::BYTE_W-1:0] data_byte,
	input  logic                        no_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mrsh_pkg::HASH_W-1:0] hash_value
);
	import mrsh_pkg::*;

	logic              ready_q;
	logic [HASH_W-1:0] seed_q;
	logic              wide_q;

	logic              valid_s1;
	item_t             item_s1;

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] pos_q;
	logic              open_q;

	logic [HASH_W-1:0] base_hash;
	logic [HASH_W-1:0] base_pos;
	logic [HASH_W-1:0] mixed_hash;
	logic [HASH_W-1:0] next_hash;
	logic [HASH_W-1:0] result_hash;
	logic              out_blocked;
	logic              consume;

	assign consume  = valid_s1 & (~item_s1.last_byte | ~out_blocked);
	assign in_stall = ~ready_q | (valid_s1 & ~consume);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			wide_q <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_SEED:      seed_q <= cfg_data;
				REG_WIDE_MODE: wide_q <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{data_byte: data_byte, no_byte: no_byte, last_byte: last_byte};
		end
	end

	assign base_hash = open_q ? hash_q : seed_q;
	assign base_pos  = open_q ? pos_q  : '0;

	mrsh_mix u_mix (
		.hash_in   (base_hash),
		.pos_in    (base_pos),
		.data_byte (item_s1.data_byte),
		.wide      (wide_q),
		.hash_out  (mixed_hash)
	);

	assign next_hash   = item_s1.no_byte ? base_hash : mixed_hash;
	assign result_hash = wide_q ? next_hash : {{(HASH_W-HALF_W){1'b0}}, next_hash[HALF_W-1:0]};

	// Hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			pos_q  <= '0;
			open_q <= 1'b0;
		end else if (consume) begin
			hash_q <= next_hash;
			pos_q  <= item_s1.no_byte ? base_pos : base_pos + HASH_W'(1);
			open_q <= ~item_s1.last_byte;
		end
	end

	mrsh_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (consume & item_s1.last_byte),
		.load_hash  (result_hash),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.hash_value (hash_value),
		.blocked    (out_blocked)
	);

endmodule

[hw/rtl/mrsh_chk.sv]
// Port-level checks for the multiply-rotate string hash, bound to the top level.
// Depends on mrsh_pkg and multiply_rotate_string_hash.
module mrsh_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [mrsh_pkg::HASH_W-1:0] hash_value
);
	import mrsh_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hash_value))
		else $error("result beat changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && $past(arst_n) |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result beat without an accepted input beat");

endmodule

bind multiply_rotate_string_hash mrsh_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hash_value (hash_value)
);

[verif/multiply_rotate_string_hash_tb.sv]
// Self-checking testbench for multiply_rotate_string_hash: directed string cases, then
// random strings under several idle and stall mixes, checked against an in-bench hash model.
// Depends on mrsh_pkg and the multiply_rotate_string_hash RTL.
module multiply_rotate_string_hash_tb;
	import mrsh_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_BEATS = 240;
	localparam logic [HASH_W-1:0] LOW_MASK = 64'h0000_0000_FFFF_FFFF;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_write_en;
	logic [0:0]        cfg_index;
	logic [HASH_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte;
	logic              no_byte;
	logic              last_byte;
	logic              out_valid;
	logic              out_stall;
	logic [HASH_W-1:0] hash_value;

	logic [HASH_W-1:0] seed_reg;
	logic              wide_reg;
	logic [HASH_W-1:0] hash_acc;
	logic [HASH_W-1:0] byte_pos;
	logic              string_live;
	logic [HASH_W-1:0] expected_hashes[$];
	logic [HASH_W-1:0] want_hash;

	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;
	int mismatches;
	int beats_sent;
	int hashes_checked;
	int cfg_writes;

	multiply_rotate_string_hash i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.no_byte      (no_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hash_value   (hash_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [ROT_W-1:0] rot_from_byte(input logic [BYTE_W-1:0] c);
		return {c[3] | c[1], c[4], c[6] | c[2], c[0]};
	endfunction

	function automatic logic [HASH_W-1:0] rotate_hash(input logic [HASH_W-1:0] v,
			input logic [ROT_W-1:0] r, input logic wide);
		logic [HASH_W-1:0] lo;
		lo = v & LOW_MASK;
		if (r == 0)
			return wide ? v : lo;
		if (wide)
			return (v << r) | (v >> (HASH_W - r));
		return ((lo << r) | (lo >> (HALF_W - r))) & LOW_MASK;
	endfunction

	function automatic void fold_byte(input logic [BYTE_W-1:0] c);
		logic [HASH_W-1:0] c_ext;
		logic [HASH_W-1:0] mix;
		c_ext = {{(HASH_W-BYTE_W){c[BYTE_W-1]}}, c};
		mix = hash_acc * (wide_reg ? MUL_WIDE : MUL_NARROW) + c_ext * CHAR_MUL
			+ byte_pos + POS_BIAS;
		if (!wide_reg)
			mix = mix & LOW_MASK;
		hash_acc = rotate_hash(mix, rot_from_byte(c), wide_reg);
		byte_pos = byte_pos + 1;
	endfunction

	function automatic void predict_hash(input logic [BYTE_W-1:0] c, input logic nob,
			input logic last);
		if (!string_live) begin
			hash_acc = seed_reg;
			byte_pos = '0;
			string_live = 1'b1;
		end
		if (!nob)
			fold_byte(c);
		if (last) begin
			expected_hashes.push_back(wide_reg ? hash_acc : (hash_acc & LOW_MASK));
			string_live = 1'b0;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
			input logic [HASH_W-1:0] want);
		$display("mismatch: %s got %h expected %h", what, got, want);
		mismatches++;
	endtask

	// Beat path: entered and left just after a falling edge; valid stays high on exit.
	task automatic send_beat(input logic [BYTE_W-1:0] c, input logic nob, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= c;
		no_byte <= nob;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		predict_hash(c, nob, last);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_hashes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [HASH_W-1:0] value);
		settle();
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_SEED)
			seed_reg = value;
		else
			wide_reg = value[0];
		cfg_writes++;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic test_empty_strings();
		send_beat(8'h00, 1'b1, 1'b1);
		write_reg(REG_SEED, '1);
		send_beat(8'hA5, 1'b1, 1'b1);
		write_reg(REG_WIDE_MODE, 64'd1);
		send_beat(8'h5A, 1'b1, 1'b1);
	endtask

	task automatic test_byte_extremes();
		logic [BYTE_W-1:0] bytes[6];
		bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h20, 8'h5F};
		for (int mode = 0; mode < 2; mode++) begin
			write_reg(REG_WIDE_MODE, 64'(mode));
			write_reg(REG_SEED, 64'h0123_4567_89AB_CDEF);
			for (int i = 0; i < 6; i++)
				send_beat(bytes[i], 1'b0, i == 5);
		end
	endtask

	task automatic test_no_byte_inside();
		send_beat(8'hC3, 1'b1, 1'b0);
		send_beat(8'h41, 1'b0, 1'b0);
		send_beat(8'h3C, 1'b1, 1'b0);
		send_beat(8'h42, 1'b0, 1'b1);
	endtask

	task automatic test_mid_string_changes();
		write_reg(REG_WIDE_MODE, 64'd1);
		write_reg(REG_SEED, 64'hFEDC_BA98_7654_3210);
		send_beat(8'h11, 1'b0, 1'b0);
		send_beat(8'h93, 1'b0, 1'b0);
		write_reg(REG_WIDE_MODE, 64'd0);
		send_beat(8'hC4, 1'b0, 1'b0);
		write_reg(REG_SEED, 64'h55);
		write_reg(REG_WIDE_MODE, 64'd1);
		send_beat(8'h3E, 1'b0, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
	endtask

	task automatic send_random_string();
		int pick;
		int len;
		pick = $urandom_range(99);
		len = (pick < 10) ? 0 : (pick < 95) ? $urandom_range(10, 1) : $urandom_range(64, 11);
		if (len == 0) begin
			send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
			return;
		end
		for (int i = 0; i < len; i++) begin
			if (len > 1 && i == len / 2 && $urandom_range(99) < 4) begin
				if ($urandom_range(1))
					write_reg(REG_WIDE_MODE, 64'(!wide_reg));
				else
					write_reg(REG_SEED, {$urandom(), $urandom()});
			end
			send_beat(8'($urandom_range(255)), $urandom_range(99) < 8, i == len - 1);
		end
	endtask

	task automatic test_random();
		int phase_start;
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 57; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 57; end
				default: begin send_idle_pct = 22; stall_pct = 22; end
			endcase
			write_reg(REG_WIDE_MODE, 64'(ph[1]));
			write_reg(REG_SEED, (ph == 0) ? 64'd0 : (ph == 3) ? '1 : {$urandom(), $urandom()});
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS)
				send_random_string();
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_hashes.size() == 0) begin
				report_mismatch("hash with none pending", hash_value, '0);
			end else begin
				want_hash = expected_hashes.pop_front();
				if (hash_value !== want_hash)
					report_mismatch("hash_value", hash_value, want_hash);
				hashes_checked++;
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("[multiply_rotate_string_hash] ERROR");
			$finish;
		end
	end

	initial begin
		cfg_write_en = 1'b0;
		cfg_index = REG_SEED;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		no_byte = 1'b0;
		last_byte = 1'b0;
		seed_reg = '0;
		wide_reg = 1'b0;
		hash_acc = '0;
		byte_pos = '0;
		string_live = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		mismatches = 0;
		beats_sent = 0;
		hashes_checked = 0;
		cfg_writes = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_strings();
		test_byte_extremes();
		test_no_byte_inside();
		test_mid_string_changes();
		test_random();

		settle();
		repeat (8) @(negedge clk);
		$display("ran %0d beats and checked %0d hashes over %0d register writes,",
			beats_sent, hashes_checked, cfg_writes);
		$display("both modes, empty strings, byte-less beats and mid-string changes");
		if (mismatches == 0)
			$display("[multiply_rotate_string_hash] OK");
		else
			$display("[multiply_rotate_string_hash] ERROR");
		$finish;
	end

endmodule
